>>> sv/vzc_pkg.sv
// Varint / zigzag codec: shared types and constants.
// Holds operation and result codes, register indexes and the command
// passed from the front end to the back end. Depends on nothing.
package vzc_pkg;

    // Input operation codes
    localparam logic [1:0] OP_ENCODE = 2'd0;
    localparam logic [1:0] OP_DECODE = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    // Result kind codes
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_VALUE     = 2'd1;
    localparam logic [1:0] KIND_OVERLONG  = 2'd2;
    localparam logic [1:0] KIND_TRUNCATED = 2'd3;

    // Configuration register indexes
    localparam logic CFG_WIDE_MODE = 1'b0;
    localparam logic CFG_ZIGZAG    = 1'b1;

    // Byte limits of the two modes
    localparam logic [3:0] LIMIT_NARROW = 4'd5;
    localparam logic [3:0] LIMIT_WIDE   = 4'd10;

    typedef struct packed {
        logic wide_mode;
        logic zigzag_enable;
    } t_cfg;

    // One queued command: an encode run or a single finished result
    typedef struct packed {
        logic        is_enc;
        logic [1:0]  kind;
        logic [63:0] value;
        logic [3:0]  count;
    } t_cmd;

endpackage

>>> sv/vzc_if.sv
// Varint / zigzag codec: valid/ready channel interfaces.
// vzc_in_if carries input items, vzc_out_if carries result items.
// No dependencies.
interface vzc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] value_in;
    logic [7:0]  byte_in;

    modport source (output valid, operation, value_in, byte_in, input ready);
    modport sink   (input valid, operation, value_in, byte_in, output ready);
endinterface

interface vzc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic [63:0] value_out;
    logic [3:0]  byte_count;
    logic        last;

    modport source (output valid, kind, byte_out, value_out, byte_count, last,
                    input ready);
    modport sink   (input valid, kind, byte_out, value_out, byte_count, last,
                    output ready);
endinterface

>>> sv/vzc_front.sv
// Varint / zigzag codec front end: accepts items, keeps the decode state,
// applies zigzag mapping and queues one command per item that yields results.
// Depends on vzc_pkg and vzc_in_if.
module vzc_front import vzc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_full,
    vzc_in_if.sink     i_in,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_seen, n_seen;

    logic        accept;
    logic [6:0]  shift_amt;
    logic [63:0] byte_bits;
    logic [63:0] acc_new;
    logic [3:0]  seen_new;
    logic [3:0]  limit;
    logic [31:0] enc32, dec32;
    logic [63:0] enc_val, dec_val;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    // Map the value to encode and the value just decoded
    always_comb begin
        limit = i_cfg.wide_mode ? LIMIT_WIDE : LIMIT_NARROW;

        enc32 = i_in.value_in[31:0];
        if (i_cfg.zigzag_enable) begin
            enc32 = {enc32[30:0], 1'b0} ^ {32{enc32[31]}};
        end
        if (i_cfg.wide_mode) begin
            enc_val = i_in.value_in;
            if (i_cfg.zigzag_enable) begin
                enc_val = {i_in.value_in[62:0], 1'b0} ^ {64{i_in.value_in[63]}};
            end
        end else begin
            enc_val = {32'b0, enc32};
        end

        shift_amt = 7'(r_seen) * 7'd7;
        byte_bits = {57'b0, i_in.byte_in[6:0]} << shift_amt[5:0];
        acc_new   = r_acc | ((shift_amt < 7'd64) ? byte_bits : 64'b0);
        seen_new  = r_seen + 4'd1;

        dec32 = acc_new[31:0];
        if (i_cfg.zigzag_enable) begin
            dec32 = {1'b0, dec32[31:1]} ^ {32{dec32[0]}};
        end
        if (i_cfg.wide_mode) begin
            dec_val = acc_new;
            if (i_cfg.zigzag_enable) begin
                dec_val = {1'b0, acc_new[63:1]} ^ {64{acc_new[0]}};
            end
        end else if (i_cfg.zigzag_enable) begin
            dec_val = {{32{dec32[31]}}, dec32};
        end else begin
            dec_val = {32'b0, dec32};
        end
    end

    // Classify the item and build its command
    always_comb begin
        n_acc  = r_acc;
        n_seen = r_seen;
        o_push = 1'b0;
        o_cmd  = '0;
        if (accept) begin
            unique case (i_in.operation)
                OP_ENCODE: begin
                    o_push       = 1'b1;
                    o_cmd.is_enc = 1'b1;
                    o_cmd.kind   = KIND_BYTE;
                    o_cmd.value  = enc_val;
                end
                OP_DECODE: begin
                    if (!i_in.byte_in[7]) begin
                        o_push      = 1'b1;
                        o_cmd.kind  = KIND_VALUE;
                        o_cmd.value = dec_val;
                        o_cmd.count = seen_new;
                        n_acc       = '0;
                        n_seen      = '0;
                    end else if (seen_new >= limit) begin
                        o_push      = 1'b1;
                        o_cmd.kind  = KIND_OVERLONG;
                        o_cmd.count = limit;
                        n_acc       = '0;
                        n_seen      = '0;
                    end else begin
                        n_acc  = acc_new;
                        n_seen = seen_new;
                    end
                end
                OP_END: begin
                    if (r_seen != 4'd0) begin
                        o_push      = 1'b1;
                        o_cmd.kind  = KIND_TRUNCATED;
                        o_cmd.count = r_seen;
                        n_acc       = '0;
                        n_seen      = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold the decode state between bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_seen <= '0;
        end else begin
            r_acc  <= n_acc;
            r_seen <= n_seen;
        end
    end

endmodule

>>> sv/vzc_queue.sv
// Varint / zigzag codec command queue between front and back end.
// A small circular buffer of t_cmd entries. Depends on vzc_pkg.
module vzc_queue import vzc_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> sv/vzc_back.sv
// Varint / zigzag codec back end: carries out queued commands, emitting
// encoded bytes one per cycle while the output is taken, or a single
// result, through an output register. Depends on vzc_pkg and vzc_out_if.
module vzc_back import vzc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    vzc_out_if.source  o_out
);

    logic        r_ov;
    logic        r_busy;
    logic [63:0] r_t;
    logic [3:0]  r_idx;
    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic [63:0] r_value;
    logic [3:0]  r_count;
    logic        r_last;

    logic        out_free;
    logic        do_enc;
    logic [63:0] src;
    logic [56:0] rest;
    logic [3:0]  idx;

    // Pick the next byte source: the running encode or a fresh command
    always_comb begin
        out_free = !r_ov || o_out.ready;
        o_pop    = out_free && !r_busy && !i_empty;
        do_enc   = r_busy || i_cmd.is_enc;
        src      = r_busy ? r_t : i_cmd.value;
        rest     = src[63:7];
        idx      = r_busy ? r_idx : 4'd0;
    end

    // Control: output valid and encode run in progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_busy <= 1'b0;
        end else if (out_free) begin
            if (r_busy || !i_empty) begin
                r_ov   <= 1'b1;
                r_busy <= do_enc && (rest != 57'b0);
            end else begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload: load the output register and the remaining encode bits
    always_ff @(posedge i_clk) begin
        if (out_free && (r_busy || !i_empty)) begin
            if (do_enc) begin
                r_kind  <= KIND_BYTE;
                r_byte  <= {rest != 57'b0, src[6:0]};
                r_value <= '0;
                r_count <= idx;
                r_last  <= (rest == 57'b0);
                r_t     <= {7'b0, rest};
                r_idx   <= idx + 4'd1;
            end else begin
                r_kind  <= i_cmd.kind;
                r_byte  <= '0;
                r_value <= i_cmd.value;
                r_count <= i_cmd.count;
                r_last  <= 1'b1;
            end
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.kind       = r_kind;
    assign o_out.byte_out   = r_byte;
    assign o_out.value_out  = r_value;
    assign o_out.byte_count = r_count;
    assign o_out.last       = r_last;

    // A run in progress is past its first byte and within ten bytes
    a_run_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx != 4'd0) && (r_idx <= 4'd9))
        else $error("encode run index out of range");

    // No command is taken while a run is still emitting
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_busy && !i_empty)
        else $error("command popped during run or from empty queue");

    // Only encoded bytes may be non-final
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_kind != KIND_BYTE)) |-> r_last)
        else $error("single result without last");

    // Continuation flag agrees with last on encoded bytes
    a_cont_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_kind == KIND_BYTE)) |-> (r_last == !r_byte[7]))
        else $error("continuation bit disagrees with last");

endmodule

>>> sv/varint_zigzag_codec.sv
// Varint / zigzag codec top level: configuration registers, front end,
// command queue and back end. Depends on vzc_pkg, vzc_if, vzc_front,
// vzc_queue and vzc_back.
//
// Usage:
//   Input items arrive on i_in (valid/ready): encode a value, decode one
//   byte, or mark the end of the data. Results leave on o_out (valid/ready).
//   Registers wide_mode (index 0) and zigzag_enable (index 1) are written
//   through i_cfg_we / i_cfg_index / i_cfg_data while the block is idle.
//   The front end takes one item per cycle while the command queue has room
//   and keeps the decode state; the back end emits one result per cycle
//   while the receiver is ready. An accepted item's command passes through
//   the queue to the output register. A decode or end item gives at most
//   one result; an encode item gives 1 to 5 bytes (narrow) or 1 to 10 bytes
//   (wide), one per cycle, so sustained encode throughput is set by the
//   byte count of the back end's run; decode runs at one byte per cycle.
//   When the receiver stalls, the output register holds its result, the
//   queue of QUEUE_DEPTH commands fills and then i_in.ready falls.
//   Synchronous reset clears the registers, decode state, queue and output.
module varint_zigzag_codec import vzc_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data,
    vzc_in_if.sink     i_in,
    vzc_out_if.source  o_out
);

    t_cfg r_cfg;
    logic push, pop, full, empty;
    t_cmd push_cmd, head_cmd;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDE_MODE: r_cfg.wide_mode     <= i_cfg_data;
                CFG_ZIGZAG:    r_cfg.zigzag_enable <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vzc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .i_in    (i_in),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    vzc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    vzc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
